// ===== rtl/core/page_frame_manager_lru_assert.svh =====
// Assertion macros for the page frame manager.
`ifndef PAGE_FRAME_MANAGER_LRU_ASSERT_SVH
`define PAGE_FRAME_MANAGER_LRU_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PFM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PFM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pfm_pkg.sv =====
`default_nettype none
package pfm_pkg;

  localparam int unsigned FRAME_OUT_W = 4;

  typedef enum logic [2:0] {
    KIND_FETCH  = 3'd0,
    KIND_UNPIN  = 3'd1,
    KIND_NEW    = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_FLUSH  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_RES   = 3'd1,
    ST_NOT_PIN   = 3'd2,
    ST_NO_FRAME  = 3'd3,
    ST_PINNED    = 3'd4,
    ST_PIN_FULL  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_CHK,
    S_VRD,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] page_id;
    logic        dirty_mark;
  } pfm_in_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [FRAME_OUT_W-1:0] frame;
    logic                   hit;
    logic                   load_needed;
    logic                   zero_needed;
    logic                   writeback_needed;
    logic [31:0]            writeback_page;
    logic [FRAME_OUT_W-1:0] writeback_frame;
  } pfm_out_t;

  typedef struct packed {
    logic rm;
    logic app;
  } lru_op_t;

endpackage
`default_nettype wire

// ===== rtl/core/pfm_ram.sv =====
`default_nettype none
module pfm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [AW-1:0]          waddr_i,
  input  wire logic [WIDTH-1:0]       wdata_i,
  input  wire logic [AW-1:0]          raddr_i,
  output logic      [WIDTH-1:0]       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/core/pfm_lru.sv =====
`default_nettype none
module pfm_lru import pfm_pkg::*; #(
  parameter int unsigned FRAMES = 16,
  localparam int unsigned FW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  localparam int unsigned CW = $clog2(FRAMES + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lru_op_t           op_i,
  input  wire logic [FW-1:0]     frame_i,
  output logic [FW-1:0]          head_o,
  output logic [CW-1:0]          len_o,
  output logic [FRAMES-1:0]      in_lru_o
);
  logic [FW-1:0]     nxt_q [FRAMES];
  logic [FW-1:0]     prv_q [FRAMES];
  logic [FW-1:0]     head_q, tail_q;
  logic [CW-1:0]     len_q;
  logic [FRAMES-1:0] in_q;
  logic [FW-1:0]     p, n;

  assign p        = prv_q[frame_i];
  assign n        = nxt_q[frame_i];
  assign head_o   = head_q;
  assign len_o    = len_q;
  assign in_lru_o = in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q  <= '0;
      len_q <= '0;
    end else if (op_i.rm) begin
      in_q[frame_i] <= 1'b0;
      len_q         <= len_q - 1'b1;
    end else if (op_i.app) begin
      in_q[frame_i] <= 1'b1;
      len_q         <= len_q + 1'b1;
    end
  end

  // unlink or link at the tail
  always_ff @(posedge clk_i) begin
    if (op_i.rm) begin
      if (head_q == frame_i) begin
        head_q <= n;
      end else begin
        nxt_q[p] <= n;
      end
      if (tail_q == frame_i) begin
        tail_q <= p;
      end else begin
        prv_q[n] <= p;
      end
    end else if (op_i.app) begin
      if (len_q == '0) begin
        head_q <= frame_i;
      end else begin
        nxt_q[tail_q] <= frame_i;
      end
      prv_q[frame_i] <= tail_q;
      tail_q         <= frame_i;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/page_frame_manager_lru.sv =====
`default_nettype none
// Page frame manager with LRU replacement. One command is taken at a time.
// The page lookup scans the frames with a single 32-bit comparator fed by the
// resident-page RAM, a read state and a compare state per frame, stopping at
// the first match; a command then passes a decision state, a victim-read
// state when a frame is evicted, and an execute state that waits while the
// output register holds a stalled result. The result sits in an output
// register, so the next command can be taken while it waits for transfer.
// Unused LRU links and resident pages need no reset; there is no clearing pass.
module page_frame_manager_lru import pfm_pkg::*; #(
  parameter int unsigned FRAMES  = 16,
  parameter int unsigned PIN_MAX = 255
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire pfm_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output pfm_out_t      out_data_o
);
  localparam int unsigned FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW = $clog2(FRAMES + 1);
  localparam int unsigned PW = $clog2(PIN_MAX + 1);

  state_e          state_q, state_d;
  pfm_in_t         cmd_q;
  logic [CW-1:0]   idx_q, idx_d;
  logic            found_q, found_d;
  logic [FW-1:0]   f_q, f_d;
  logic            out_valid_q;
  pfm_out_t        out_q;
  logic [31:0]     hit_cnt_q, miss_cnt_q;
  logic [FRAMES-1:0] valid_q, dirty_q;
  logic [PW-1:0]   pin_q [FRAMES];
  logic [FW-1:0]   fs_q [FRAMES];
  logic [CW-1:0]   fcnt_q;

  logic [FW-1:0]   raddr;
  logic [31:0]     rdata;
  logic            ram_we;
  logic [FW-1:0]   head;
  logic [CW-1:0]   lru_len;
  logic [FRAMES-1:0] in_lru;
  lru_op_t         lru_op;
  logic [FW-1:0]   lru_f;

  logic            go;
  pfm_out_t        res;
  logic            wr;
  logic [FW-1:0]   tgt;
  logic            nv, nd;
  logic [PW-1:0]   np;
  logic            pop, push, hit_inc, miss_inc;
  logic            tk_ok, tk_vic;
  logic [FW-1:0]   tk_f;
  logic [CW-1:0]   fm1;

  pfm_ram #(.WIDTH(32), .DEPTH(FRAMES)) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tgt),
    .wdata_i (cmd_q.page_id),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pfm_lru #(.FRAMES(FRAMES)) u_lru (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (lru_op),
    .frame_i  (lru_f),
    .head_o   (head),
    .len_o    (lru_len),
    .in_lru_o (in_lru)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign go          = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign raddr       = (state_q == S_RD) ? idx_q[FW-1:0] : head;
  assign fm1         = fcnt_q - 1'b1;

  always_comb begin
    tk_ok  = 1'b0;
    tk_vic = 1'b0;
    tk_f   = head;
    if (fcnt_q != '0) begin
      tk_ok = 1'b1;
      tk_f  = fs_q[fm1[FW-1:0]];
    end else if (lru_len != '0) begin
      tk_ok  = 1'b1;
      tk_vic = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    found_d = found_q;
    f_d     = f_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_RD;
          idx_d   = '0;
          found_d = 1'b0;
          f_d     = '0;
        end
      end
      S_RD: state_d = S_CMP;
      S_CMP: begin
        if (valid_q[idx_q[FW-1:0]] && (rdata == cmd_q.page_id)) begin
          found_d = 1'b1;
          f_d     = idx_q[FW-1:0];
          state_d = S_CHK;
        end else if (idx_q == CW'(FRAMES - 1)) begin
          state_d = S_CHK;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_CHK: begin
        if (!found_q && tk_vic &&
            ((cmd_q.kind == KIND_FETCH) || (cmd_q.kind == KIND_NEW))) begin
          state_d = S_VRD;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_VRD: state_d = S_EXEC;
      S_EXEC: begin
        if (go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res      = '0;
    wr       = 1'b0;
    tgt      = f_q;
    nv       = valid_q[f_q];
    nd       = dirty_q[f_q];
    np       = pin_q[f_q];
    ram_we   = 1'b0;
    pop      = 1'b0;
    push     = 1'b0;
    hit_inc  = 1'b0;
    miss_inc = 1'b0;
    lru_op   = '0;
    lru_f    = f_q;
    case (cmd_q.kind) inside
      KIND_FETCH, KIND_NEW: begin
        if (found_q) begin
          if ((cmd_q.kind == KIND_FETCH) && (pin_q[f_q] >= PW'(PIN_MAX))) begin
            res.status = ST_PIN_FULL;
          end else if ((cmd_q.kind == KIND_NEW) && (pin_q[f_q] != '0)) begin
            res.status = ST_PINNED;
          end else begin
            wr        = 1'b1;
            lru_op.rm = in_lru[f_q];
            res.frame = FRAME_OUT_W'(f_q);
            if (cmd_q.kind == KIND_FETCH) begin
              hit_inc = 1'b1;
              np      = pin_q[f_q] + 1'b1;
              res.hit = 1'b1;
            end else begin
              ram_we          = 1'b1;
              nv              = 1'b1;
              np              = PW'(1);
              nd              = 1'b1;
              res.zero_needed = 1'b1;
            end
          end
        end else begin
          miss_inc = (cmd_q.kind == KIND_FETCH);
          if (!tk_ok) begin
            res.status = ST_NO_FRAME;
          end else begin
            pop    = !tk_vic;
            tgt    = tk_f;
            wr     = 1'b1;
            ram_we = 1'b1;
            nv     = 1'b1;
            np     = PW'(1);
            nd     = (cmd_q.kind == KIND_NEW);
            res.frame       = FRAME_OUT_W'(tk_f);
            res.load_needed = (cmd_q.kind == KIND_FETCH);
            res.zero_needed = (cmd_q.kind == KIND_NEW);
            if (tk_vic) begin
              lru_op.rm = 1'b1;
              lru_f     = tk_f;
              if (dirty_q[tk_f]) begin
                res.writeback_needed = 1'b1;
                res.writeback_page   = rdata;
                res.writeback_frame  = FRAME_OUT_W'(tk_f);
              end
            end
          end
        end
      end
      KIND_UNPIN: begin
        if (!found_q) begin
          res.status = ST_NOT_RES;
        end else if (pin_q[f_q] == '0) begin
          res.status = ST_NOT_PIN;
        end else begin
          wr         = 1'b1;
          nd         = dirty_q[f_q] | cmd_q.dirty_mark;
          np         = pin_q[f_q] - 1'b1;
          lru_op.app = (pin_q[f_q] == PW'(1));
          res.frame  = FRAME_OUT_W'(f_q);
        end
      end
      KIND_DELETE: begin
        if (found_q) begin
          if (pin_q[f_q] != '0) begin
            res.status = ST_PINNED;
          end else begin
            lru_op.rm = in_lru[f_q];
            wr        = 1'b1;
            nv        = 1'b0;
            nd        = 1'b0;
            np        = '0;
            push      = (fcnt_q < CW'(FRAMES));
          end
        end
      end
      KIND_FLUSH: begin
        if (!found_q) begin
          res.status = ST_NOT_RES;
        end else begin
          res.frame = FRAME_OUT_W'(f_q);
          if (dirty_q[f_q]) begin
            wr                   = 1'b1;
            nd                   = 1'b0;
            res.writeback_needed = 1'b1;
            res.writeback_page   = cmd_q.page_id;
            res.writeback_frame  = FRAME_OUT_W'(f_q);
          end
        end
      end
      default: ;
    endcase
    if (!go) begin
      wr       = 1'b0;
      ram_we   = 1'b0;
      pop      = 1'b0;
      push     = 1'b0;
      hit_inc  = 1'b0;
      miss_inc = 1'b0;
      lru_op   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      valid_q     <= '0;
      dirty_q     <= '0;
      fcnt_q      <= CW'(FRAMES);
      for (int i = 0; i < FRAMES; i++) begin
        pin_q[i] <= '0;
        fs_q[i]  <= FW'(FRAMES - 1 - i);
      end
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (hit_inc) begin
        hit_cnt_q <= hit_cnt_q + 1'b1;
      end
      if (miss_inc) begin
        miss_cnt_q <= miss_cnt_q + 1'b1;
      end
      if (wr) begin
        valid_q[tgt] <= nv;
        dirty_q[tgt] <= nd;
        pin_q[tgt]   <= np;
      end
      if (pop) begin
        fcnt_q <= fm1;
      end else if (push) begin
        fs_q[fcnt_q[FW-1:0]] <= f_q;
        fcnt_q               <= fcnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    f_q   <= f_d;
    if (in_valid_i && !in_stall_o) begin
      cmd_q <= in_data_i;
    end
    if (go) begin
      out_q <= res;
    end
  end

`include "page_frame_manager_lru_assert.svh"

  `PFM_ASSERT_IMP(a_frames_disjoint, 1'b1,
    ({1'b0, fcnt_q} + {1'b0, lru_len}) <= (CW + 1)'(FRAMES),
    "free and LRU frames exceed frame count")
  `PFM_ASSERT_NXT(a_accept_busy, in_valid_i && !in_stall_o, state_q == S_RD,
    "accepted command did not start lookup")
  `PFM_ASSERT_IMP(a_err_clean, out_valid_o && (out_data_o.status != ST_OK),
    (out_data_o.frame == '0) && !out_data_o.writeback_needed && !out_data_o.hit,
    "error result carries payload")

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import pfm_pkg::*;

  class frame_pool_scoreboard;
    logic [31:0] page_of[16];
    bit          valid_f[16];
    int unsigned pins[16];
    bit          dirty_f[16];
    bit [3:0]    lru_q[$];
    bit [3:0]    free_stk[$];
    logic [31:0] hits, misses;
    pfm_out_t    pending_q[$];
    int          errors;

    function void clear_state();
      for (int i = 0; i < 16; i++) begin
        valid_f[i] = 0;
        pins[i] = 0;
        dirty_f[i] = 0;
      end
      lru_q.delete();
      free_stk.delete();
      for (int i = 15; i >= 0; i--) free_stk.insert(free_stk.size(), i[3:0]);
      hits = 0;
      misses = 0;
      errors = 0;
    endfunction

    function int find_page(logic [31:0] pid);
      for (int i = 0; i < 16; i++)
        if (valid_f[i] && page_of[i] == pid) return i;
      return -1;
    endfunction

    function void lru_drop(int f);
      for (int i = 0; i < lru_q.size(); i++)
        if (lru_q[i] == f) begin
          lru_q.delete(i);
          return;
        end
    endfunction

    function int grab_frame(ref pfm_out_t r);
      int v;
      if (free_stk.size() > 0) begin
        v = free_stk[free_stk.size() - 1];
        free_stk.delete(free_stk.size() - 1);
        return v;
      end
      if (lru_q.size() == 0) return -1;
      v = lru_q[0];
      if (valid_f[v] && dirty_f[v]) begin
        r.writeback_needed = 1;
        r.writeback_page = page_of[v];
        r.writeback_frame = v[3:0];
      end
      lru_drop(v);
      valid_f[v] = 0;
      dirty_f[v] = 0;
      pins[v] = 0;
      return v;
    endfunction

    function void note_command(pfm_in_t c);
      pfm_out_t r;
      int f;
      status_e st;
      r = '0;
      st = ST_OK;
      case (c.kind)
        KIND_FETCH: begin
          f = find_page(c.page_id);
          if (f >= 0) begin
            if (pins[f] >= 255) st = ST_PIN_FULL;
            else begin
              hits++;
              pins[f]++;
              lru_drop(f);
              r.frame = f[3:0];
              r.hit = 1;
            end
          end else begin
            misses++;
            f = grab_frame(r);
            if (f < 0) st = ST_NO_FRAME;
            else begin
              page_of[f] = c.page_id;
              valid_f[f] = 1;
              pins[f] = 1;
              dirty_f[f] = 0;
              r.frame = f[3:0];
              r.load_needed = 1;
            end
          end
        end
        KIND_UNPIN: begin
          f = find_page(c.page_id);
          if (f < 0) st = ST_NOT_RES;
          else if (pins[f] == 0) st = ST_NOT_PIN;
          else begin
            if (c.dirty_mark) dirty_f[f] = 1;
            pins[f]--;
            if (pins[f] == 0 && lru_q.size() < 16) lru_q.insert(lru_q.size(), f[3:0]);
            r.frame = f[3:0];
          end
        end
        KIND_NEW: begin
          f = find_page(c.page_id);
          if (f >= 0) begin
            if (pins[f] > 0) st = ST_PINNED;
            else lru_drop(f);
          end else begin
            f = grab_frame(r);
            if (f < 0) st = ST_NO_FRAME;
          end
          if (st == ST_OK) begin
            page_of[f] = c.page_id;
            valid_f[f] = 1;
            pins[f] = 1;
            dirty_f[f] = 1;
            r.frame = f[3:0];
            r.zero_needed = 1;
          end
        end
        KIND_DELETE: begin
          f = find_page(c.page_id);
          if (f >= 0) begin
            if (pins[f] > 0) st = ST_PINNED;
            else begin
              lru_drop(f);
              valid_f[f] = 0;
              dirty_f[f] = 0;
              pins[f] = 0;
              if (free_stk.size() < 16) free_stk.insert(free_stk.size(), f[3:0]);
            end
          end
        end
        KIND_FLUSH: begin
          f = find_page(c.page_id);
          if (f < 0) st = ST_NOT_RES;
          else begin
            if (dirty_f[f]) begin
              r.writeback_needed = 1;
              r.writeback_page = page_of[f];
              r.writeback_frame = f[3:0];
              dirty_f[f] = 0;
            end
            r.frame = f[3:0];
          end
        end
        default: ;
      endcase
      if (st != ST_OK) r = '0;
      r.status = st;
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void check_result(pfm_out_t got);
      pfm_out_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got !== e) begin
        $display("%0t: expected %p actual %p", $time, e, got);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i, rst_ni, in_valid_i, out_stall_i;
  logic     in_stall_o, out_valid_o;
  pfm_in_t  in_data_i;
  pfm_out_t out_data_o;

  frame_pool_scoreboard sb;
  bit          idle_en;
  bit          hold_req;
  int unsigned cycles;
  logic [31:0] page_set[20];

  page_frame_manager_lru dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);

  initial begin
    int burst, hold;
    out_stall_i = 0;
    burst = 0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        hold = 250;
      end
      if (hold > 0) begin
        out_stall_i <= 1;
        hold--;
      end else if (!idle_en) out_stall_i <= 0;
      else if (burst > 0) begin
        out_stall_i <= 1;
        burst--;
      end else if ($urandom_range(0, 7) == 0) begin
        out_stall_i <= 1;
        burst = $urandom_range(0, 5);
      end else out_stall_i <= 0;
    end
  end

  task automatic send(input logic [2:0] k, input logic [31:0] pid, input bit mark);
    pfm_in_t c;
    int gap;
    c.kind = k;
    c.page_id = pid;
    c.dirty_mark = mark;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      in_valid_i <= 0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1;
    in_data_i <= c;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_command(c);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_command();
    int sel;
    logic [31:0] pid;
    logic [2:0] k;
    sel = $urandom_range(0, 99);
    pid = ($urandom_range(0, 99) < 88) ? page_set[$urandom_range(0, 19)] : $urandom;
    if (sel < 30) k = KIND_FETCH;
    else if (sel < 70) k = KIND_UNPIN;
    else if (sel < 78) k = KIND_NEW;
    else if (sel < 86) k = KIND_DELETE;
    else if (sel < 95) k = KIND_FLUSH;
    else k = 3'($urandom_range(5, 7));
    send(k, pid, $urandom_range(0, 1));
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    cycles = 0;
    idle_en = 1;
    hold_req = 0;
    rst_ni = 0;
    in_valid_i = 0;
    in_data_i = '0;
    for (int i = 0; i < 20; i++) page_set[i] = $urandom;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    send(KIND_FETCH, 32'h0, 0);
    send(KIND_FETCH, 32'hFFFF_FFFF, 1);
    send(KIND_FETCH, 32'h0, 0);
    send(KIND_UNPIN, 32'h0, 1);
    send(KIND_UNPIN, 32'h0, 0);
    send(KIND_UNPIN, 32'h0, 0);
    send(KIND_UNPIN, 32'h1234_5678, 0);
    send(KIND_FLUSH, 32'h0, 0);
    send(KIND_FLUSH, 32'h0, 0);
    send(KIND_FLUSH, 32'hAAAA_5555, 0);
    send(KIND_NEW, 32'h7, 0);
    send(KIND_NEW, 32'h7, 0);
    send(KIND_DELETE, 32'h7, 0);
    send(KIND_UNPIN, 32'h7, 0);
    send(KIND_NEW, 32'h7, 0);
    send(KIND_UNPIN, 32'h7, 1);
    send(KIND_DELETE, 32'h7, 0);
    send(KIND_DELETE, 32'h99, 0);
    send(3'd5, 32'h5555_AAAA, 1);
    send(3'd6, 32'h0, 0);
    send(3'd7, 32'hFFFF_FFFF, 1);
    for (int i = 0; i < 17; i++) send(KIND_FETCH, 32'h100 + i, 0);
    for (int i = 0; i < 16; i++) send(KIND_UNPIN, 32'h100 + i, i[0]);
    send(KIND_FETCH, 32'h200, 0);
    send(KIND_NEW, 32'h201, 0);

    for (int i = 0; i < 256; i++) send(KIND_FETCH, page_set[0], 0);
    for (int i = 0; i < 256; i++) send(KIND_UNPIN, page_set[0], i[4]);

    for (int i = 0; i < 830; i++) begin
      if (i == 200) hold_req = 1;
      if (i == 450) drain();
      if (i == 650) idle_en = 0;
      random_command();
    end

    drain();
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
